### hdl/ppfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared types and fixed constants of the pH probe filter and converter.
// ----------------------------------------------------------------------------
package ppfc_pkg;

  // signed Q8.8 pH word, wide enough for every instant and averaged value
  typedef logic signed [15:0] ph_q8_t;
  // calibration offset, 1/256 pH units
  typedef logic signed [11:0] offset_t;
  // result field word
  typedef logic [12:0] out_word_t;

  // pH 7 in Q8.8
  localparam int PH_NEUTRAL_Q8 = 1792;
  // 2 * 32000: slope term of the pH formula, doubled for half-up rounding
  localparam int PH_SLOPE2     = 64000;
  // rounding addend factor (9 * N * F) and divisor factor (18 * N)
  localparam int PH_ROUND_K    = 9;
  localparam int PH_DIV_K      = 18;
  // bias that keeps the quotient operand non-negative
  localparam int PH_BIAS       = 4096;
  // output saturation limit
  localparam int PH_MAX_OUT    = 8191;
  // millivolt scale, doubled for half-up rounding
  localparam int MV_SCALE2     = 10000;

endpackage

### hdl/ppfc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_if
// Valid/ready channels of the pH probe filter: samples, results, offset.
// ----------------------------------------------------------------------------
interface ppfc_in_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ppfc_out_if;
  import ppfc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t ph_value;
  out_word_t probe_millivolts;

  modport source (output valid, output ph_value, output probe_millivolts, input ready);
  modport sink   (input valid, input ph_value, input probe_millivolts, output ready);
endinterface

interface ppfc_cfg_if;
  import ppfc_pkg::*;
  logic    valid;
  logic    ready;
  offset_t cal_offset;

  modport source (output valid, output cal_offset, input ready);
  modport sink   (input valid, input cal_offset, output ready);
endinterface

### hdl/ppfc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_cell
// One window entry: holds a sample and hands it to the next cell on a shift.
// ----------------------------------------------------------------------------
module ppfc_cell #(
  parameter int WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic [WIDTH-1:0] data_in,
  output logic [WIDTH-1:0] data_out
);

  logic [WIDTH-1:0] data_r;
  logic [WIDTH-1:0] data_nxt;

  assign data_nxt = shift_en ? data_in : data_r;

  // window starts out full of zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_out = data_r;

endmodule

### hdl/ppfc_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfc_convert
// Window sum to pH and millivolts: constant divides, second average, clamp.
// ----------------------------------------------------------------------------
module ppfc_convert #(
  parameter int WINDOW_LEN = 36,
  parameter int ADC_BITS   = 10,
  localparam int SUM_W     = $clog2(WINDOW_LEN * (1 << ADC_BITS))
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  logic [SUM_W-1:0]   s_sum,
  input  ppfc_pkg::offset_t  offset,
  ppfc_out_if.source         out_ch
);
  import ppfc_pkg::*;

  localparam int NF   = WINDOW_LEN * (1 << ADC_BITS);
  localparam int DIVP = PH_DIV_K * WINDOW_LEN;
  localparam int T_W  = SUM_W + 20;
  localparam int U_W  = $clog2(137738 * WINDOW_LEN);
  localparam int A_W  = $clog2(5001 * WINDOW_LEN);
  localparam int M_W  = SUM_W + 15;

  localparam logic [13:0] MU = 14'((1 << U_W) / DIVP);
  localparam logic [13:0] MA = 14'((1 << A_W) / WINDOW_LEN);

  // stage valids and readiness
  logic v2_r, v3_r, out_valid_r;
  logic rdy2, rdy3, rdy_out;

  assign rdy_out = !out_valid_r || out_ch.ready;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign s_ready = rdy2;

  // stage 2: biased pH dividend and millivolt dividend
  logic signed [SUM_W+1:0] dsum;
  logic signed [T_W-1:0]   tnum;
  logic signed [T_W-1:0]   tsh;
  logic [M_W-1:0]          mnum;
  logic [U_W-1:0]          u2_nxt, u2_r;
  logic [A_W-1:0]          a2_nxt, a2_r;

  always_comb begin
    dsum   = (SUM_W+2)'(NF) - ((SUM_W+2)'(s_sum) <<< 1);
    tnum   = T_W'(dsum) * T_W'(PH_SLOPE2) + T_W'(PH_ROUND_K * NF);
    tsh    = (tnum >>> ADC_BITS) + T_W'(PH_BIAS * DIVP);
    u2_nxt = U_W'(tsh);
    mnum   = M_W'(s_sum) * M_W'(MV_SCALE2) + M_W'(NF);
    a2_nxt = A_W'(mnum >> (ADC_BITS + 1));
  end

  // stage 3: reciprocal estimates, low by at most one
  logic [U_W+13:0] prod_u;
  logic [A_W+13:0] prod_a;
  logic [12:0]     qe3_nxt, qe3_r;
  logic [12:0]     ae3_nxt, ae3_r;
  logic [U_W-1:0]  u3_r;
  logic [A_W-1:0]  a3_r;

  always_comb begin
    prod_u  = (U_W+14)'(u2_r) * (U_W+14)'(MU);
    prod_a  = (A_W+14)'(a2_r) * (A_W+14)'(MA);
    qe3_nxt = 13'(prod_u >> U_W);
    ae3_nxt = 13'(prod_a >> A_W);
  end

  // stage 4: correction, instant pH, second average, clamp
  ph_q8_t           avg_r, avg_nxt;
  logic [U_W-1:0]   rem_u;
  logic [A_W-1:0]   rem_a;
  logic [12:0]      quo;
  logic [12:0]      mv;
  ph_q8_t           p_inst;
  ph_q8_t           seed;
  logic signed [16:0] sum2;
  out_word_t        ph_nxt;

  always_comb begin
    rem_u   = u3_r - U_W'(U_W'(qe3_r) * U_W'(DIVP));
    quo     = qe3_r + ((rem_u >= U_W'(DIVP)) ? 13'd1 : 13'd0);
    rem_a   = a3_r - A_W'(A_W'(ae3_r) * A_W'(WINDOW_LEN));
    mv      = ae3_r + ((rem_a >= A_W'(WINDOW_LEN)) ? 13'd1 : 13'd0);
    p_inst  = ph_q8_t'(PH_NEUTRAL_Q8) + ph_q8_t'(offset)
            + ph_q8_t'(signed'({3'b000, quo})) - ph_q8_t'(PH_BIAS);
    seed    = (avg_r == '0) ? p_inst : avg_r;
    sum2    = 17'(seed) + 17'(p_inst);
    avg_nxt = ph_q8_t'(sum2 >>> 1);
    if (avg_nxt < 0) begin
      ph_nxt = '0;
    end else if (avg_nxt > ph_q8_t'(PH_MAX_OUT)) begin
      ph_nxt = out_word_t'(PH_MAX_OUT);
    end else begin
      ph_nxt = out_word_t'(avg_nxt);
    end
  end

  out_word_t out_ph_r, out_mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      avg_r       <= '0;
    end else begin
      if (rdy2) begin
        v2_r <= s_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_out) begin
        out_valid_r <= v3_r;
      end
      if (rdy_out && v3_r) begin
        avg_r <= avg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      u2_r <= u2_nxt;
      a2_r <= a2_nxt;
    end
    if (rdy3) begin
      qe3_r <= qe3_nxt;
      ae3_r <= ae3_nxt;
      u3_r  <= u2_r;
      a3_r  <= a2_r;
    end
    if (rdy_out && v3_r) begin
      out_ph_r <= ph_nxt;
      out_mv_r <= mv;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.ph_value         = out_ph_r;
  assign out_ch.probe_millivolts = out_mv_r;

endmodule

### hdl/ph_probe_filter_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ph_probe_filter_convert
// Moving-average pH probe filter with linear conversion to pH and millivolts.
// ----------------------------------------------------------------------------
// One result transaction comes out for every sample transaction, in order.
// A new sample can be taken every cycle while the output side is free: the
// block is a four-register pipeline (window update, dividend build,
// reciprocal estimate, correction plus output register), and ready steps
// back through it, so bubbles fill up while a result waits at the output.
// The sample window is a chain of WINDOW_LEN cells that shift once per
// sample and are zeroed by reset, so the zeros count in the mean until the
// window has filled. The calibration offset is written through the cfg
// channel, which is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module ph_probe_filter_convert #(
  parameter int WINDOW_LEN = 36,
  parameter int ADC_BITS   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  ppfc_in_if.sink     in_ch,
  ppfc_out_if.source  out_ch,
  ppfc_cfg_if.sink    cfg_ch
);
  import ppfc_pkg::*;

  localparam int SUM_W = $clog2(WINDOW_LEN * (1 << ADC_BITS));

  // calibration offset register
  offset_t offset_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_ch.valid) begin
      offset_r <= cfg_ch.cal_offset;
    end
  end

  // stage 1 handshake: window state doubles as the stage register
  logic v1_r;
  logic conv_ready;
  logic in_acc;

  assign in_ch.ready = !v1_r || conv_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // first running average, seeded with the sample while it reads zero
  logic [ADC_BITS-1:0] raw_avg_r, raw_avg_nxt;
  logic [ADC_BITS-1:0] raw_seed;
  logic [ADC_BITS:0]   raw_sum;

  always_comb begin
    raw_seed    = (raw_avg_r == '0) ? in_ch.adc_sample : raw_avg_r;
    raw_sum     = {1'b0, raw_seed} + {1'b0, in_ch.adc_sample};
    raw_avg_nxt = raw_sum[ADC_BITS:1];
  end

  // window cell chain: newest enters cell 0, oldest leaves the last cell
  logic [ADC_BITS-1:0] tap [WINDOW_LEN];

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
      logic [ADC_BITS-1:0] cell_in;
      if (gi == 0) begin : g_head
        assign cell_in = raw_avg_nxt;
      end else begin : g_link
        assign cell_in = tap[gi-1];
      end
      ppfc_cell #(
        .WIDTH (ADC_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_acc),
        .data_in  (cell_in),
        .data_out (tap[gi])
      );
    end
  endgenerate

  // running window sum: drop the oldest entry, add the new average
  logic [SUM_W-1:0] sum_r, sum_nxt;

  assign sum_nxt = sum_r - SUM_W'(tap[WINDOW_LEN-1]) + SUM_W'(raw_avg_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      raw_avg_r <= '0;
      sum_r     <= '0;
    end else begin
      if (in_acc) begin
        v1_r      <= 1'b1;
        raw_avg_r <= raw_avg_nxt;
        sum_r     <= sum_nxt;
      end else if (conv_ready) begin
        v1_r <= 1'b0;
      end
    end
  end

  // conversion pipeline and output register
  ppfc_convert #(
    .WINDOW_LEN (WINDOW_LEN),
    .ADC_BITS   (ADC_BITS)
  ) u_convert (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v1_r),
    .s_ready (conv_ready),
    .s_sum   (sum_r),
    .offset  (offset_r),
    .out_ch  (out_ch)
  );

endmodule

### tb/tb_ph_probe_filter_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ph_probe_filter_convert
// Self-checking bench for the pH probe filter and converter. A behavioral
// model of both running averages, the sample window and the pH / millivolt
// conversion predicts every result. Results are compared field by field, in
// order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ph_probe_filter_convert;
  import ppfc_pkg::*;

  localparam int WINDOW_LEN  = 36;
  localparam int ADC_BITS    = 10;
  localparam int ADC_MAX     = (1 << ADC_BITS) - 1;
  // generous bound for the whole run, with both sides stalling at random
  localparam int CYCLE_LIMIT = 500000;
  // pipeline depth plus some margin for the final quiet check
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 100;

  // one result transaction as the model sees it
  typedef struct packed {
    out_word_t ph;
    out_word_t mv;
  } reading_t;

  logic clk;
  logic rst_n;

  ppfc_in_if #(.ADC_BITS(ADC_BITS)) in_ch ();
  ppfc_out_if                       out_ch ();
  ppfc_cfg_if                       cfg_ch ();

  ph_probe_filter_convert #(
    .WINDOW_LEN(WINDOW_LEN),
    .ADC_BITS  (ADC_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // --------------------------------------------------------------------------
  // model state, mirrors the block right after reset
  // --------------------------------------------------------------------------
  offset_t            m_offset   = '0;
  logic [9:0]         m_raw_avg  = '0;
  logic [9:0]         m_ring [WINDOW_LEN] = '{default: '0};
  int                 m_wr_idx   = 0;
  logic [15:0]        m_win_sum  = '0;
  int                 m_ph_avg   = 0;

  // readings predicted for accepted samples, oldest first
  reading_t expected_readings[$];

  int mismatch_count = 0;
  int cycle_count    = 0;

  // idle control, percent chance of a gap after each transaction
  int tx_stall_pct = 0;
  int rx_stall_pct = 0;
  // long output hold-off, consumed by the receiver process
  int rx_hold_left = 0;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // floor of n / d for positive d
  function automatic longint floor_quot(input longint n, input longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // advances the model by one sample and returns the reading it produces
  function automatic reading_t predict_reading(input logic [9:0] adc);
    longint   nf;
    longint   den;
    longint   num;
    int       inst_ph;
    int       shown;
    reading_t r;

    // first running average, seeded while it reads zero
    if (m_raw_avg == 0) m_raw_avg = adc;
    m_raw_avg = 10'((int'(m_raw_avg) + int'(adc)) >> 1);

    // window ring with running sum
    m_win_sum = m_win_sum - m_ring[m_wr_idx] + m_raw_avg;
    m_ring[m_wr_idx] = m_raw_avg;
    m_wr_idx++;
    if (m_wr_idx >= WINDOW_LEN) m_wr_idx = 0;

    // pH = 7 + (2.5 - V) / 0.18 + offset, Q8.8, rounded half up
    nf  = longint'(WINDOW_LEN) << ADC_BITS;
    den = 9 * nf;
    num = longint'(1792 + int'(m_offset)) * den
        + 64'sd32000 * (nf - 2 * longint'(m_win_sum));
    inst_ph = int'(floor_quot(2 * num + den, 2 * den));

    // second running average, arithmetic halving
    if (m_ph_avg == 0) m_ph_avg = inst_ph;
    m_ph_avg = (m_ph_avg + inst_ph) >>> 1;

    shown = m_ph_avg;
    if (shown < 0) shown = 0;
    if (shown > 8191) shown = 8191;

    r.ph = out_word_t'(shown);
    r.mv = out_word_t'((longint'(m_win_sum) * 10000 + nf) / (2 * nf));
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // offers one sample, waits for its transaction, records the prediction
  task automatic send_sample(input logic [9:0] adc);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= adc;
    do @(posedge clk); while (!in_ch.ready);
    expected_readings = {expected_readings, predict_reading(adc)};
    gap = pick_gap(tx_stall_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pauses until every outstanding reading has been checked
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // offset is only written while the pipeline is empty
  task automatic write_offset(input offset_t value);
    wait_drained();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.cal_offset <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    m_offset = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // steady probe level with a little noise, some wild readings
  function automatic logic [9:0] next_sample(input int level);
    int v;
    if (level == 0) return '0;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, ADC_MAX);
      1: v = level;
      default: v = level + int'($urandom_range(0, 16)) - 8;
    endcase
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return v[9:0];
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // zero seeding of both averages, extremes, window filling with reset zeros
  task automatic test_seeding_and_extremes();
    send_sample(10'd0);
    send_sample(ADC_MAX[9:0]);   // raw average is zero, seeds with full scale
    send_sample(ADC_MAX[9:0]);
    // ten zeros decay the raw average back to exactly zero
    repeat (10) send_sample(10'd0);
    send_sample(10'd0);           // reseeds with zero
    send_sample(10'd700);         // reseeds with a nonzero value
    send_sample(10'd1);
  endtask

  // offset extremes, all offset bits toggled
  task automatic test_offset_extremes();
    offset_t offsets [3] = '{12'sh7FF, 12'sh800, 12'shFFF};
    foreach (offsets[i]) begin
      write_offset(offsets[i]);
      send_sample(10'd0);
      send_sample(ADC_MAX[9:0]);
    end
    write_offset('0);
  endtask

  // output held off for a long stretch while samples keep coming
  task automatic test_output_hold_fill();
    tx_stall_pct = 0;
    rx_stall_pct = 0;
    rx_hold_left = 300;
    repeat (48) send_sample(10'($urandom_range(0, ADC_MAX)));
    wait_drained();
  endtask

  // bursts, each followed by a full drain
  task automatic test_burst_drain();
    tx_stall_pct = 20;
    rx_stall_pct = 20;
    repeat (8) begin
      repeat (10) send_sample(10'($urandom_range(0, ADC_MAX)));
      wait_drained();
    end
  endtask

  // long random run in phases with different offsets and idle settings
  task automatic test_random_phases();
    int level;
    int run_left;
    int phase_tx [6] = '{0, 30, 10, 60, 25, 5};
    int phase_rx [6] = '{0, 30, 60, 10, 25, 5};
    offset_t phase_off;
    level    = 0;
    run_left = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: phase_off = '0;
        1: phase_off = 12'sh800;
        2: phase_off = 12'sh7FF;
        5: phase_off = -12'sd300;
        default: phase_off = offset_t'($urandom_range(0, 4095));
      endcase
      write_offset(phase_off);
      tx_stall_pct = phase_tx[ph];
      rx_stall_pct = phase_rx[ph];
      repeat (150) begin
        if (run_left == 0) begin
          case ($urandom_range(0, 5))
            0: level = 0;          // quiet probe, lets the raw average reseed
            1: level = ADC_MAX;    // drives pH below zero, exercises the clamp
            default: level = $urandom_range(1, ADC_MAX);
          endcase
          run_left = $urandom_range(20, 80);
        end
        run_left--;
        send_sample(next_sample(level));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stalls plus the long hold-off counted here
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap(rx_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker, compares each result transaction with the oldest prediction
  // --------------------------------------------------------------------------
  reading_t want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result, ph_value", int'(out_ch.ph_value), -1);
      end else begin
        want = expected_readings.pop_front();
        if (out_ch.ph_value !== want.ph)
          report_mismatch("ph_value", int'(out_ch.ph_value), int'(want.ph));
        if (out_ch.probe_millivolts !== want.mv)
          report_mismatch("probe_millivolts", int'(out_ch.probe_millivolts),
                          int'(want.mv));
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ph_probe_filter_convert NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    // every input known from time zero
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.adc_sample  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.cal_offset <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_seeding_and_extremes();
    test_offset_extremes();
    test_output_hold_fill();
    test_burst_drain();
    test_random_phases();

    // everything accepted: wait for the last results, then watch for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("tb_ph_probe_filter_convert OK");
    end else begin
      $display("tb_ph_probe_filter_convert NOT OK");
    end
    $finish;
  end

endmodule
